// ----- rtl/rsf_pkg.sv -----
`default_nettype none

package rsf_pkg;

    // Command codes carried in the input tuser field
    localparam logic [1:0] FUNC_RECT = 2'd0;
    localparam logic [1:0] FUNC_DISC = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    // Configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Field widths
    localparam int FUNC_W  = 2;
    localparam int POS_W   = 12;
    localparam int SIZE_W  = 10;
    localparam int COLOR_W = 32;
    localparam int CFG_W   = 9;
    localparam int CNT_W   = 17;

    // Signed coordinate width: covers a 12-bit signed center +- 1023, edges -3071 .. 3070
    localparam int CW = 14;

    localparam logic [CNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [CFG_W-1:0] FRAME_RESET = 9'd256;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

endpackage

`default_nettype wire

// ----- rtl/rgba_shape_fill_rasterizer_top.sv -----
`default_nettype none

// Channel   Direction  Signals                              Payload
// s_*       in         s_tvalid s_tready s_tdata s_tuser    one command
// m_*       out        m_tvalid m_tready m_tdata m_tuser    one result per command
// cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data  register write
//
// Read: setup (multiplier), then the store read and its wait state, then the result.
// Fill: walks the clipped bounding box row by row; each row
// prologue runs the shared multiplier three times, then one pixel per cycle.
// After reset the store is cleared one word a cycle, all MAX_WIDTH*MAX_HEIGHT
// words (65536 by default), with s_tready low; cfg writes are taken throughout.
// s_tready is high only while idle; a result holds on m_* until transferred.
module rgba_shape_fill_rasterizer_top #(
    parameter int MAX_WIDTH  = rsf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rsf_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // pos_x[11:0] pos_y[23:12] size_x[33:24] size_y[43:34] radius[53:44]
    // red[61:54] green[69:62] blue[77:70] alpha[85:78], zero fill to 88
    input  wire logic [87:0]                 s_tdata,
    // func[1:0]
    input  wire logic [1:0]                  s_tuser,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // pixels_written[16:0] read_red[24:17] read_green[32:25]
    // read_blue[40:33] read_alpha[48:41], zero fill to 56
    output logic [55:0]                      m_tdata,
    // read_in_bounds[0]
    output logic [0:0]                       m_tuser,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic                        cfg_index,
    input  wire logic [rsf_pkg::CFG_W-1:0]   cfg_data
);

    localparam int CW    = rsf_pkg::CW;
    localparam int PW    = 2 * CW;
    localparam int WORDS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic signed [CW-1:0] ONE = CW'(1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_SETUP2,
        S_ROW0,
        S_ROW1,
        S_ROW2,
        S_ROW3,
        S_PIXEL,
        S_RD_ADDR,
        S_RD_WAIT,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [rsf_pkg::CFG_W-1:0] width_reg, height_reg;

    // Command registers
    logic [1:0]                  func_reg, func_next;
    logic signed [CW-1:0]        cx_reg, cx_next, cy_reg, cy_next;
    logic [rsf_pkg::SIZE_W-1:0]  sx_reg, sx_next, sy_reg, sy_next, r_reg, r_next;
    logic [rsf_pkg::COLOR_W-1:0] color_reg, color_next;

    // Walk registers
    logic signed [CW-1:0] x0_reg, x0_next, x1_reg, x1_next;
    logic signed [CW-1:0] y0_reg, y0_next, y1_reg, y1_next;
    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next, dx_reg, dx_next;
    logic signed [PW-1:0] dx2_reg, dx2_next, dy2_reg, dy2_next, r2_reg, r2_next;
    logic [AW-1:0]        base_reg, base_next, addr_reg, addr_next;
    logic [AW-1:0]        clr_reg, clr_next;

    // Result registers
    logic [rsf_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        inb_reg, inb_next;
    logic [rsf_pkg::COLOR_W-1:0] rd_reg, rd_next;

    // Shared multiplier
    logic signed [CW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_reg;

    // Store port
    logic [rsf_pkg::COLOR_W-1:0] mem [WORDS];
    logic [rsf_pkg::COLOR_W-1:0] rdata_reg;
    logic                        we;
    logic [AW-1:0]               waddr;
    logic [rsf_pkg::COLOR_W-1:0] wdata;
    logic                        rd_en;
    logic [AW-1:0]               raddr;

    // Setup datapath
    logic signed [CW-1:0] eff_w, eff_h;
    logic [10:0]          hx_sum, hy_sum;
    logic signed [CW-1:0] hx, hy, rr;
    logic signed [CW-1:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [CW-1:0] bx0, bx1, by0, by1;
    logic                 rd_inside;
    logic signed [PW:0]   dist2;
    logic                 hit;

    // Clamp the registers to the store geometry
    always_comb
    begin
        eff_w = (32'(width_reg) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(width_reg);
        eff_h = (32'(height_reg) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(height_reg);
    end

    // Bounding box, clipped to 1 .. size-1 on each axis
    always_comb
    begin
        hx_sum = {1'b0, sx_reg} + {10'b0, sx_reg[0]};
        hy_sum = {1'b0, sy_reg} + {10'b0, sy_reg[0]};
        hx     = CW'(hx_sum[10:1]);
        hy     = CW'(hy_sum[10:1]);
        rr     = CW'(r_reg);
        if (func_reg == rsf_pkg::FUNC_RECT)
        begin
            lo_x = cx_reg - hx;
            hi_x = cx_reg + hx - ONE;
            lo_y = cy_reg - hy;
            hi_y = cy_reg + hy - ONE;
        end
        else
        begin
            lo_x = cx_reg - rr;
            hi_x = cx_reg + rr;
            lo_y = cy_reg - rr;
            hi_y = cy_reg + rr;
        end
        bx0 = (lo_x > ONE) ? lo_x : ONE;
        by0 = (lo_y > ONE) ? lo_y : ONE;
        bx1 = (hi_x < eff_w - ONE) ? hi_x : eff_w - ONE;
        by1 = (hi_y < eff_h - ONE) ? hi_y : eff_h - ONE;
        rd_inside = (cx_reg >= ONE) && (cy_reg >= ONE) && (cx_reg < eff_w) && (cy_reg < eff_h);
    end

    // Strict inside test of the disc; rectangles always hit
    always_comb
    begin
        dist2 = (PW+1)'(dx2_reg) + (PW+1)'(dy2_reg);
        hit   = (func_reg == rsf_pkg::FUNC_RECT) || (dist2 < (PW+1)'(r2_reg));
    end

    // Select multiplier operands by step
    always_comb
    begin
        mul_a = eff_w;
        mul_b = y_reg - ONE;
        unique case (state_reg)
            S_SETUP:
            begin
                if (func_reg == rsf_pkg::FUNC_READ)
                begin
                    mul_a = eff_w;
                    mul_b = cy_reg - ONE;
                end
                else
                begin
                    mul_a = rr;
                    mul_b = rr;
                end
            end
            S_ROW1:
            begin
                mul_a = y_reg - cy_reg;
                mul_b = y_reg - cy_reg;
            end
            S_ROW2:
            begin
                mul_a = x0_reg - cx_reg;
                mul_b = x0_reg - cx_reg;
            end
            default:
            begin
                mul_a = eff_w;
                mul_b = y_reg - ONE;
            end
        endcase
    end

    // Store write and read ports
    always_comb
    begin
        we    = 1'b0;
        waddr = addr_reg;
        wdata = color_reg;
        if (state_reg == S_CLEAR)
        begin
            we    = 1'b1;
            waddr = clr_reg;
            wdata = '0;
        end
        else if (state_reg == S_PIXEL)
        begin
            we = hit;
        end
        rd_en = (state_reg == S_RD_ADDR);
        raddr = AW'(mul_reg) + AW'(cx_reg);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        r_next     = r_reg;
        color_next = color_reg;
        x0_next    = x0_reg;
        x1_next    = x1_reg;
        y0_next    = y0_reg;
        y1_next    = y1_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        dx_next    = dx_reg;
        dx2_next   = dx2_reg;
        dy2_next   = dy2_reg;
        r2_next    = r2_reg;
        base_next  = base_reg;
        addr_next  = addr_reg;
        clr_next   = clr_reg;
        cnt_next   = cnt_reg;
        inb_next   = inb_reg;
        rd_next    = rd_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next  = s_tuser;
                    cx_next    = CW'($signed(s_tdata[11:0]));
                    cy_next    = CW'($signed(s_tdata[23:12]));
                    sx_next    = s_tdata[33:24];
                    sy_next    = s_tdata[43:34];
                    r_next     = s_tdata[53:44];
                    color_next = s_tdata[85:54];
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cnt_next = '0;
                inb_next = 1'b0;
                rd_next  = '0;
                x0_next  = bx0;
                x1_next  = bx1;
                y0_next  = by0;
                y1_next  = by1;
                case (func_reg)
                    rsf_pkg::FUNC_RECT, rsf_pkg::FUNC_DISC: state_next = S_SETUP2;
                    rsf_pkg::FUNC_READ: state_next = rd_inside ? S_RD_ADDR : S_OUT;
                    default: state_next = S_OUT;
                endcase
            end
            S_SETUP2:
            begin
                r2_next = mul_reg;
                y_next  = y0_reg;
                if ((x0_reg > x1_reg) || (y0_reg > y1_reg))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_ROW0;
                end
            end
            S_ROW0:
            begin
                state_next = S_ROW1;
            end
            S_ROW1:
            begin
                base_next  = AW'(mul_reg);
                state_next = S_ROW2;
            end
            S_ROW2:
            begin
                dy2_next   = mul_reg;
                state_next = S_ROW3;
            end
            S_ROW3:
            begin
                dx2_next   = mul_reg;
                x_next     = x0_reg;
                dx_next    = x0_reg - cx_reg;
                addr_next  = base_reg + AW'(x0_reg);
                state_next = S_PIXEL;
            end
            S_PIXEL:
            begin
                if (hit && (cnt_reg != rsf_pkg::COUNT_MAX))
                begin
                    cnt_next = cnt_reg + rsf_pkg::CNT_W'(1);
                end
                dx2_next  = dx2_reg + PW'(dx_reg) + PW'(dx_reg) + PW'(1);
                dx_next   = dx_reg + ONE;
                x_next    = x_reg + ONE;
                addr_next = addr_reg + AW'(1);
                if (x_reg == x1_reg)
                begin
                    if (y_reg == y1_reg)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        y_next     = y_reg + ONE;
                        state_next = S_ROW0;
                    end
                end
            end
            S_RD_ADDR:
            begin
                state_next = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                inb_next   = 1'b1;
                rd_next    = rdata_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, clear counter and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            width_reg  <= rsf_pkg::FRAME_RESET;
            height_reg <= rsf_pkg::FRAME_RESET;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    rsf_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    rsf_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        r_reg     <= r_next;
        color_reg <= color_next;
        x0_reg    <= x0_next;
        x1_reg    <= x1_next;
        y0_reg    <= y0_next;
        y1_reg    <= y1_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        dx_reg    <= dx_next;
        dx2_reg   <= dx2_next;
        dy2_reg   <= dy2_next;
        r2_reg    <= r2_next;
        base_reg  <= base_next;
        addr_reg  <= addr_next;
        cnt_reg   <= cnt_next;
        inb_reg   <= inb_next;
        rd_reg    <= rd_next;
        mul_reg   <= mul_a * mul_b;
    end

    // Frame store
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Drive the ports
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = {7'b0, rd_reg, cnt_reg};
    assign m_tuser   = inb_reg;

    // Checks
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_SETUP))
        else $error("accepted command did not start setup");

    a_walk_x: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PIXEL) |-> ((x_reg >= x0_reg) && (x_reg <= x1_reg)))
        else $error("pixel walk left the box on x");

    a_walk_y: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PIXEL) |-> ((y_reg >= y0_reg) && (y_reg <= y1_reg)))
        else $error("pixel walk left the box on y");

    a_read_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[16:0] == '0))
        else $error("read result carries a pixel count");

endmodule

`default_nettype wire
